// ===== design/optt_pkg.sv =====
// ----------------------------------------------------------------------------
// optt_pkg
// Shared request codes, status codes, entry modes and controller states.
// ----------------------------------------------------------------------------
package optt_pkg;

    typedef enum logic [2:0] {
        REQ_ARM_PERIODIC = 3'd0,
        REQ_ARM_AT       = 3'd1,
        REQ_DISCHARGE    = 3'd2,
        REQ_UNWARP       = 3'd3,
        REQ_CLEAR        = 3'd4,
        REQ_RUN          = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONE     = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_ARMED      = 2'd1,
        MODE_DISCHARGED = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CHK,
        S_ARM_WR,
        S_UNW_RD,
        S_UNW_WR,
        S_RUN_RD,
        S_RUN_CHK,
        S_FIRE_OUT,
        S_DONE
    } state_t;

endpackage

// ===== design/oneshot_periodic_timer_table_unit.sv =====
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_table_unit
// Table of one-shot and periodic timers keyed by ID, with times in us.
// ----------------------------------------------------------------------------
// One request is worked at a time. Entries live in a memory (key, deadline,
// period) and a mode array, both with a registered read; arm, discharge,
// unwarp and run walk the filled entries one at a time (read, then check
// and write back), and arm and discharge stop at the entry whose key
// matches. Run fires in table order and compacts in the same pass: each
// kept entry is written back at the write pointer, which never runs ahead
// of the read pointer, and the minimum deadline is tracked on the fly. A
// new request is taken only after the completion of the previous one has
// been loaded into the output register. The entry mode array is held in
// flip-flops and cleared at reset, so the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_table_unit #(
    parameter int SLOTS     = 16,
    parameter int KEY_BITS  = 32,
    parameter int TIME_BITS = 52
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // req_type[2:0], timer_key, time_value, now_us; zero padded to bytes
    input  logic [((3 + KEY_BITS + 2*TIME_BITS + 7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast,
    // result_kind, fired_key, fired_late, status[1:0], next_delay; zero padded
    output logic [((1 + KEY_BITS + 1 + 2 + TIME_BITS + 7)/8)*8-1:0] m_tdata
);
    import optt_pkg::*;

    localparam int OW = ((1 + KEY_BITS + 1 + 2 + TIME_BITS + 7)/8)*8;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // entry memory
    logic [KEY_BITS-1:0]  key_mem [SLOTS];
    logic [TIME_BITS-1:0] dl_mem  [SLOTS];
    logic [TIME_BITS-1:0] per_mem [SLOTS];
    logic [1:0]           mode_reg [SLOTS];

    logic [KEY_BITS-1:0]  rd_key_reg;
    logic [TIME_BITS-1:0] rd_dl_reg, rd_per_reg;
    logic [1:0]           rd_mode_reg;

    logic                 we;
    logic [AW-1:0]        wa, ra;
    logic [KEY_BITS-1:0]  wkey;
    logic [TIME_BITS-1:0] wdl, wper;
    logic [1:0]           wmode;
    logic                 clr_all;

    always_ff @(posedge aclk) begin
        if (we) begin
            key_mem[wa] <= wkey;
            dl_mem[wa]  <= wdl;
            per_mem[wa] <= wper;
        end
        rd_key_reg <= key_mem[ra];
        rd_dl_reg  <= dl_mem[ra];
        rd_per_reg <= per_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) mode_reg[k] <= MODE_IDLE;
        end else if (clr_all) begin
            for (int k = 0; k < SLOTS; k++) mode_reg[k] <= MODE_IDLE;
        end else if (we) begin
            mode_reg[wa] <= wmode;
        end
    end
    always_ff @(posedge aclk) rd_mode_reg <= mode_reg[ra];

    // request registers
    state_t                state_reg, state_next;
    logic [2:0]            req_reg;
    logic [KEY_BITS-1:0]   rkey_reg;
    logic [TIME_BITS-1:0]  tv_reg, now_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic                  hit_reg, hit_next;
    logic [AW-1:0]         hidx_reg, hidx_next;
    logic [TIME_BITS-1:0]  min_reg, min_next;
    logic [TIME_BITS-1:0]  ndl_reg, ndl_next;
    logic                  fkeep_reg, fkeep_next;

    // output register
    logic                  ov_reg;
    logic [OW-1:0]         od_reg;
    logic                  ol_reg;
    logic                  load;
    logic [OW-1:0]         load_d;
    logic                  load_l;

    assign s_tready = (state_reg == S_IDLE) && aresetn;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    wire   out_free = !ov_reg || m_tready;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                      input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [OW-1:0] pack(input logic kind, input logic [KEY_BITS-1:0] k,
                                            input logic late, input logic [1:0] st,
                                            input logic [TIME_BITS-1:0] d);
        logic [OW-1:0] v;
        v = '0;
        v[0] = kind;
        v[KEY_BITS:1] = k;
        v[KEY_BITS+1] = late;
        v[KEY_BITS+3:KEY_BITS+2] = st;
        v[KEY_BITS+4+TIME_BITS-1:KEY_BITS+4] = d;
        return v;
    endfunction

    // derived values of the entry just read
    logic [TIME_BITS-1:0] unw_lim, fire_dl, fire_rb;
    logic                 due, keep_nf;
    status_t              fin_status;
    logic [TIME_BITS-1:0] fin_delay;
    always_comb begin
        unw_lim = sat_add(now_reg, rd_per_reg);
        fire_dl = sat_add(rd_dl_reg, rd_per_reg);
        fire_rb = sat_add(now_reg, rd_per_reg);
        due     = (rd_mode_reg == MODE_ARMED) && (rd_dl_reg <= now_reg);
        keep_nf = (rd_mode_reg == MODE_ARMED);
    end

    always_comb begin
        fin_status = ST_OK;
        fin_delay  = '0;
        case (req_reg)
            REQ_ARM_PERIODIC, REQ_ARM_AT:
                if (!hit_reg && cnt_reg == CW'(SLOTS)) fin_status = ST_FULL;
            REQ_DISCHARGE:
                if (!hit_reg) fin_status = ST_NOTFOUND;
            REQ_RUN: begin
                if (j_reg == '0) fin_status = ST_NONE;
                else fin_delay = (min_reg > now_reg) ? min_reg - now_reg : '0;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) begin
                case (s_tdata[2:0])
                    REQ_ARM_PERIODIC, REQ_ARM_AT, REQ_DISCHARGE: state_next = S_LOOK_RD;
                    REQ_UNWARP:  state_next = S_UNW_RD;
                    REQ_RUN:     state_next = S_RUN_RD;
                    default:     state_next = S_DONE;
                endcase
            end
            S_LOOK_RD:
                state_next = (i_reg < cnt_reg) ? S_LOOK_CHK
                           : (req_reg == REQ_DISCHARGE) ? S_DONE : S_ARM_WR;
            S_LOOK_CHK:
                if (rd_key_reg == rkey_reg)
                    state_next = (req_reg == REQ_DISCHARGE) ? S_DONE : S_ARM_WR;
                else state_next = S_LOOK_RD;
            S_ARM_WR:  state_next = S_DONE;
            S_UNW_RD:  state_next = (i_reg < cnt_reg) ? S_UNW_WR : S_DONE;
            S_UNW_WR:  state_next = S_UNW_RD;
            S_RUN_RD:  state_next = (i_reg < cnt_reg) ? S_RUN_CHK : S_DONE;
            S_RUN_CHK: state_next = due ? S_FIRE_OUT : S_RUN_RD;
            S_FIRE_OUT: if (out_free) state_next = S_RUN_RD;
            S_DONE:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ra = i_reg[AW-1:0];
        we = 1'b0; wa = '0; wkey = rd_key_reg; wdl = rd_dl_reg; wper = rd_per_reg;
        wmode = MODE_ARMED; clr_all = 1'b0;
        cnt_next = cnt_reg; i_next = i_reg; j_next = j_reg;
        hit_next = hit_reg; hidx_next = hidx_reg; min_next = min_reg;
        ndl_next = ndl_reg; fkeep_next = fkeep_reg;
        load = 1'b0; load_d = '0; load_l = 1'b0;
        case (state_reg)
            S_IDLE: begin
                i_next = '0; j_next = '0; hit_next = 1'b0; min_next = TMAX;
                ra = '0;
                if (s_tvalid && s_tdata[2:0] == REQ_CLEAR) begin
                    clr_all = 1'b1; cnt_next = '0;
                end
            end
            S_LOOK_RD: ra = i_reg[AW-1:0];
            S_LOOK_CHK: begin
                if (rd_key_reg == rkey_reg) begin
                    hit_next = 1'b1; hidx_next = i_reg[AW-1:0];
                    if (req_reg == REQ_DISCHARGE) begin
                        we = 1'b1; wa = i_reg[AW-1:0]; wmode = MODE_DISCHARGED;
                    end
                end else begin
                    i_next = i_reg + 1'b1; ra = AW'(i_reg + 1'b1);
                end
            end
            S_ARM_WR: begin
                if (hit_reg || cnt_reg != CW'(SLOTS)) begin
                    we = 1'b1; wkey = rkey_reg; wmode = MODE_ARMED;
                    wa = hit_reg ? hidx_reg : cnt_reg[AW-1:0];
                    if (req_reg == REQ_ARM_PERIODIC) begin
                        wper = tv_reg; wdl = sat_add(now_reg, tv_reg);
                    end else begin
                        wper = '0; wdl = tv_reg;
                    end
                    // mark the new slot as taken so the completion reports ok
                    if (!hit_reg) begin
                        cnt_next = cnt_reg + 1'b1;
                        hit_next = 1'b1;
                    end
                end
            end
            S_UNW_RD: ;
            S_UNW_WR: begin
                we = 1'b1; wa = i_reg[AW-1:0]; wmode = rd_mode_reg;
                if (rd_per_reg != '0 && rd_dl_reg > unw_lim) wdl = unw_lim;
                i_next = i_reg + 1'b1; ra = AW'(i_reg + 1'b1);
            end
            S_RUN_RD: ;
            S_RUN_CHK: begin
                if (due) begin
                    fkeep_next = (rd_per_reg != '0);
                    ndl_next = (fire_dl < now_reg) ? fire_rb : fire_dl;
                    ra = i_reg[AW-1:0];
                end else begin
                    if (keep_nf) begin
                        we = 1'b1; wa = j_reg[AW-1:0]; wmode = MODE_ARMED;
                        j_next = j_reg + 1'b1;
                        if (rd_dl_reg < min_reg) min_next = rd_dl_reg;
                    end
                    i_next = i_reg + 1'b1; ra = AW'(i_reg + 1'b1);
                end
            end
            S_FIRE_OUT: begin
                ra = i_reg[AW-1:0];
                if (out_free) begin
                    load = 1'b1; load_l = 1'b0;
                    load_d = pack(1'b0, rd_key_reg, rd_dl_reg < now_reg, ST_OK, '0);
                    if (fkeep_reg) begin
                        we = 1'b1; wa = j_reg[AW-1:0]; wdl = ndl_reg; wmode = MODE_ARMED;
                        j_next = j_reg + 1'b1;
                        if (ndl_reg < min_reg) min_next = ndl_reg;
                    end
                    i_next = i_reg + 1'b1; ra = AW'(i_reg + 1'b1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load = 1'b1; load_l = 1'b1;
                    load_d = pack(1'b1, '0, 1'b0, fin_status, fin_delay);
                    if (req_reg == REQ_RUN) begin
                        cnt_next = j_reg;
                        clr_all = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next; j_reg <= j_next; hit_reg <= hit_next; hidx_reg <= hidx_next;
        min_reg <= min_next; ndl_reg <= ndl_next; fkeep_reg <= fkeep_next;
        if (load) begin
            od_reg <= load_d; ol_reg <= load_l;
        end
        if (state_reg == S_IDLE && s_tvalid) begin
            req_reg  <= s_tdata[2:0];
            rkey_reg <= s_tdata[3+KEY_BITS-1:3];
            tv_reg   <= s_tdata[3+KEY_BITS+TIME_BITS-1:3+KEY_BITS];
            now_reg  <= s_tdata[3+KEY_BITS+2*TIME_BITS-1:3+KEY_BITS+TIME_BITS];
        end
    end

endmodule

// ===== design/optt_checker.sv =====
// ----------------------------------------------------------------------------
// optt_checker
// Port-level checks for the timer table unit.
// ----------------------------------------------------------------------------
module optt_checker #(
    parameter int OW = 96
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic          m_tlast,
    input logic [OW-1:0] m_tdata
);
    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // the last result is always a completion
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[0])
        else $error("last result is not a completion");

    // a fire result is never last
    a_fire_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> !m_tlast)
        else $error("fire result marked last");

    // no request is taken in the cycle after one was taken
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");
endmodule

bind oneshot_periodic_timer_table_unit optt_checker #(
    .OW(((1 + KEY_BITS + 1 + 2 + TIME_BITS + 7)/8)*8)
) u_optt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tdata(m_tdata)
);
